// File: rtl/ioubt_pkg.sv
package ioubt_pkg;

	// Default coordinate width: Q11.4 signed edges, unsigned sizes one bit narrower.
	localparam int unsigned COORD_WIDTH_DEF = 16;

	// Operand half width of the shared multiplier at the default coordinate width.
	localparam int unsigned MUL_W_DEF = 16;

	// Threshold register: unsigned Q0.16 fraction, reset value is 0.3.
	localparam int unsigned THR_W     = 16;
	localparam logic [THR_W-1:0] THR_RESET = 16'd19661;
	// One in Q0.16, the scale that multiplies the best intersection.
	localparam int unsigned THR_ONE   = 65536;

	// Configuration port.
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;
	// Word index of the threshold register (byte address divided by four).
	localparam logic [PADDR_W-3:0] REG_KEEP_THR = '0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TAREA,
		ST_AREA,
		ST_INTER,
		ST_UNION,
		ST_CMP,
		ST_DRAIN,
		ST_PICK,
		ST_FIN
	} state_t;

	// Position of a partial product within the full product.
	typedef enum logic [1:0] {
		SH_NONE,
		SH_HALF,
		SH_FULL
	} shift_t;

	// Command to the shared multiply-accumulate unit.
	typedef struct packed {
		logic   issue;
		logic   clr;
		logic   neg;
		shift_t shift;
	} mac_op_t;

endpackage

// File: rtl/ioubt_if.sv
interface ioubt_det_if #(
	parameter int unsigned COORD_WIDTH = ioubt_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] det_x;
	logic signed [COORD_WIDTH-1:0] det_y;
	logic        [COORD_WIDTH-2:0] det_w;
	logic        [COORD_WIDTH-2:0] det_h;
	logic                          last_in_frame;

	modport source (
		output valid, det_x, det_y, det_w, det_h, last_in_frame,
		input  ready
	);
	modport sink (
		input  valid, det_x, det_y, det_w, det_h, last_in_frame,
		output ready
	);
endinterface

interface ioubt_trk_if #(
	parameter int unsigned COORD_WIDTH = ioubt_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] track_x;
	logic signed [COORD_WIDTH-1:0] track_y;
	logic        [COORD_WIDTH-2:0] track_w;
	logic        [COORD_WIDTH-2:0] track_h;
	logic                          track_valid;
	logic                          box_changed;

	modport source (
		output valid, track_x, track_y, track_w, track_h, track_valid, box_changed,
		input  ready
	);
	modport sink (
		input  valid, track_x, track_y, track_w, track_h, track_valid, box_changed,
		output ready
	);
endinterface

// File: rtl/ioubt_mac.sv
module ioubt_mac #(
	parameter int unsigned MUL_W = ioubt_pkg::MUL_W_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ioubt_pkg::mac_op_t        op,
	input  logic [MUL_W-1:0]          a,
	input  logic [MUL_W-1:0]          b,
	output logic [2*MUL_W-1:0]        prod,
	output logic signed [4*MUL_W:0]   acc
);
	import ioubt_pkg::*;

	localparam int unsigned PROD_W = 2 * MUL_W;
	localparam int unsigned ACC_W  = 4 * MUL_W + 1;

	logic [PROD_W-1:0]       prod_s1;
	mac_op_t                 op_s1;
	logic [ACC_W-1:0]        term;
	logic signed [ACC_W-1:0] sterm;
	logic signed [ACC_W-1:0] acc_q;

	// The product is registered before it is placed and accumulated.
	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
		end else begin
			op_s1 <= op;
		end
	end

	always_comb begin
		case (op_s1.shift)
			SH_NONE: term = ACC_W'(prod_s1);
			SH_HALF: term = ACC_W'(prod_s1) << MUL_W;
			SH_FULL: term = ACC_W'(prod_s1) << PROD_W;
			default: term = '0;
		endcase
		sterm = op_s1.neg ? -$signed(term) : $signed(term);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (op_s1.issue) begin
			acc_q <= op_s1.clr ? sterm : acc_q + sterm;
		end
	end

	assign prod = prod_s1;
	assign acc  = acc_q;

endmodule

// File: rtl/iou_box_tracker.sv
// Greedy single-box tracker. Detections of one frame arrive one word each on det, the word
// with last_in_frame set closing the frame; after that word one result word appears on trk
// with the track as it stands after the frame. With an empty track the first detection of
// largest area is adopted; otherwise the detection of best IoU against the track is chosen
// and kept only if its IoU reaches the keep threshold (APB register at byte address 0,
// unsigned Q0.16, reset 0.3), else the track is cleared to zero. All comparisons are exact
// cross products on a single shared multiply-accumulate unit, so a detection is taken
// only once the block is through with the previous one, and a closing detection also
// waits for the previous result word to be taken. An item may be accepted while a
// result word still waits on trk.
module iou_box_tracker #(
	parameter int unsigned COORD_WIDTH = ioubt_pkg::COORD_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ioubt_pkg::PADDR_W-1:0]   paddr,
	input  logic [ioubt_pkg::PDATA_W-1:0]   pwdata,
	output logic [ioubt_pkg::PDATA_W-1:0]   prdata,
	output logic                            pready,
	ioubt_det_if.sink                       det,
	ioubt_trk_if.source                     trk
);
	import ioubt_pkg::*;

	localparam int unsigned CW      = COORD_WIDTH;
	localparam int unsigned SW      = COORD_WIDTH - 1;
	// Half width of the multiplier: holds a size plus one bit, and the threshold.
	localparam int unsigned MUL_W   = (SW + 1 > THR_W) ? SW + 1 : THR_W;
	localparam int unsigned OPW     = 2 * MUL_W;
	localparam int unsigned PROD_W  = 2 * MUL_W;
	localparam int unsigned ACC_W   = 4 * MUL_W + 1;
	localparam int unsigned INTER_W = 2 * SW;
	localparam int unsigned UNI_W   = 2 * SW + 1;
	localparam logic [2:0]  K_LAST  = '1;

	// Overlap of two intervals along one axis; never longer than the shorter one.
	function automatic logic [SW-1:0] overlap(
		input logic signed [CW-1:0] a0,
		input logic        [SW-1:0] alen,
		input logic signed [CW-1:0] b0,
		input logic        [SW-1:0] blen
	);
		logic signed [CW+1:0] a0x;
		logic signed [CW+1:0] b0x;
		logic signed [CW+1:0] a1;
		logic signed [CW+1:0] b1;
		logic signed [CW+1:0] lo;
		logic signed [CW+1:0] hi;
		logic signed [CW+1:0] diff;
		a0x  = (CW+2)'(a0);
		b0x  = (CW+2)'(b0);
		a1   = a0x + (CW+2)'($signed({1'b0, alen}));
		b1   = b0x + (CW+2)'($signed({1'b0, blen}));
		lo   = (a0x > b0x) ? a0x : b0x;
		hi   = (a1 < b1) ? a1 : b1;
		diff = hi - lo;
		return (hi > lo) ? diff[SW-1:0] : '0;
	endfunction

	state_t state_q, state_d;

	// Sequencer registers.
	logic [2:0]  k_q;
	logic        final_q;
	logic        last_q;
	logic        first_q;

	// Current detection.
	logic signed [CW-1:0] dx_q, dy_q;
	logic        [SW-1:0] dw_q, dh_q;

	// Track and best candidate of the frame.
	logic signed [CW-1:0] tx_q, ty_q, bx_q, by_q;
	logic        [SW-1:0] tw_q, th_q, bw_q, bh_q;
	logic [INTER_W-1:0]   best_inter_q;
	logic [UNI_W-1:0]     best_union_q;
	logic [THR_W-1:0]     thr_q;

	// Scratch of one detection.
	logic [SW-1:0]        ovx_q, ovy_q;
	logic [INTER_W-1:0]   tarea_q, area_q;
	logic [INTER_W-1:0]   cand_inter_q;
	logic [UNI_W-1:0]     cand_union_q;

	// Result word.
	logic                 out_valid_q;
	logic                 changed_q;

	// Shared unit.
	mac_op_t              mac_op;
	logic [MUL_W-1:0]     mac_a, mac_b;
	logic [PROD_W-1:0]    prod;
	logic signed [ACC_W-1:0] acc;

	logic                 adopt;
	logic                 acc_gt;
	logic                 out_load;
	logic                 cfg_wr;
	logic [OPW-1:0]       op_p, op_q, op_r, op_s, op_first, op_second;
	logic signed [CW-1:0] nx, ny;
	logic        [SW-1:0] nw, nh;

	ioubt_mac #(
		.MUL_W (MUL_W)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (mac_op),
		.a      (mac_a),
		.b      (mac_b),
		.prod   (prod),
		.acc    (acc)
	);

	// The track is fixed within a frame, so the branch is known from its size alone.
	assign adopt  = (tw_q == '0) || (th_q == '0);
	// Positive difference of the two cross products.
	assign acc_gt = !acc[ACC_W-1] && (acc != '0);

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_KEEP_THR);
	assign prdata = (paddr[PADDR_W-1:2] == REG_KEEP_THR) ? PDATA_W'(thr_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_wr) begin
			thr_q <= pwdata[THR_W-1:0];
		end
	end

	// Operands of the cross comparison P*Q > R*S. Within a frame it compares the
	// candidate score with the best so far; at the close it compares the threshold
	// times the best union with the best intersection scaled by one in Q0.16.
	always_comb begin
		op_q = OPW'(best_union_q);
		op_r = OPW'(best_inter_q);
		if (final_q) begin
			op_p = OPW'(thr_q);
			op_s = OPW'(THR_ONE);
		end else begin
			op_p = OPW'(cand_inter_q);
			op_s = OPW'(cand_union_q);
		end
		op_first  = k_q[2] ? op_r : op_p;
		op_second = k_q[2] ? op_s : op_q;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (det.valid) state_d = ST_TAREA;
			ST_TAREA: state_d = ST_AREA;
			ST_AREA:  state_d = ST_INTER;
			ST_INTER: state_d = ST_UNION;
			ST_UNION: state_d = ST_CMP;
			ST_CMP:   if (k_q == K_LAST) state_d = ST_DRAIN;
			ST_DRAIN: state_d = final_q ? ST_FIN : ST_PICK;
			ST_PICK: begin
				if (!last_q) begin
					state_d = ST_IDLE;
				end else if (adopt) begin
					state_d = ST_FIN;
				end else begin
					state_d = ST_CMP;
				end
			end
			ST_FIN:   if (out_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		mac_op    = '0;
		mac_a     = '0;
		mac_b     = '0;
		det.ready = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE:  det.ready = 1'b1;
			ST_TAREA: begin
				mac_a = MUL_W'(tw_q);
				mac_b = MUL_W'(th_q);
			end
			ST_AREA: begin
				mac_a = MUL_W'(dw_q);
				mac_b = MUL_W'(dh_q);
			end
			ST_INTER: begin
				mac_a = MUL_W'(ovx_q);
				mac_b = MUL_W'(ovy_q);
			end
			ST_CMP: begin
				// Partial k: bit 2 picks the subtracted product, bits 1 and 0 the halves.
				mac_op.issue = 1'b1;
				mac_op.clr   = (k_q == '0);
				mac_op.neg   = k_q[2];
				mac_a = k_q[1] ? op_first[OPW-1:MUL_W]  : op_first[MUL_W-1:0];
				mac_b = k_q[0] ? op_second[OPW-1:MUL_W] : op_second[MUL_W-1:0];
				case (k_q[1:0])
					2'b00:   mac_op.shift = SH_NONE;
					2'b11:   mac_op.shift = SH_FULL;
					default: mac_op.shift = SH_HALF;
				endcase
			end
			ST_FIN:   out_load = !out_valid_q || trk.ready;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			final_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_UNION: begin
					k_q     <= '0;
					final_q <= 1'b0;
				end
				ST_CMP:   k_q <= k_q + 3'd1;
				ST_PICK: begin
					k_q     <= '0;
					final_q <= 1'b1;
				end
				default:  ;
			endcase
		end
	end

	// Detection and per-detection scratch; the sequencer knows when they are valid.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && det.valid) begin
			dx_q   <= det.det_x;
			dy_q   <= det.det_y;
			dw_q   <= det.det_w;
			dh_q   <= det.det_h;
			last_q <= det.last_in_frame;
		end
		if (state_q == ST_AREA) begin
			tarea_q <= prod[INTER_W-1:0];
			ovx_q   <= overlap(dx_q, dw_q, tx_q, tw_q);
			ovy_q   <= overlap(dy_q, dh_q, ty_q, th_q);
		end
		if (state_q == ST_INTER) begin
			area_q <= prod[INTER_W-1:0];
		end
		if (state_q == ST_UNION) begin
			// With an empty track the score is the area over a union of one.
			if (adopt) begin
				cand_inter_q <= area_q;
				cand_union_q <= UNI_W'(1);
			end else begin
				cand_inter_q <= prod[INTER_W-1:0];
				cand_union_q <= UNI_W'(area_q) + UNI_W'(tarea_q) - UNI_W'(prod[INTER_W-1:0]);
			end
		end
	end

	// Box that the closing detection leaves as the track: a best IoU below the
	// threshold clears the track in the tracking branch.
	always_comb begin
		if (!adopt && acc_gt) begin
			nx = '0;
			ny = '0;
			nw = '0;
			nh = '0;
		end else begin
			nx = bx_q;
			ny = by_q;
			nw = bw_q;
			nh = bh_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_q         <= '0;
			ty_q         <= '0;
			tw_q         <= '0;
			th_q         <= '0;
			bx_q         <= '0;
			by_q         <= '0;
			bw_q         <= '0;
			bh_q         <= '0;
			best_inter_q <= '0;
			best_union_q <= UNI_W'(1);
			first_q      <= 1'b1;
			changed_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (trk.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_UNION: begin
					// The first detection of a frame is the candidate to beat.
					if (first_q) begin
						bx_q         <= dx_q;
						by_q         <= dy_q;
						bw_q         <= dw_q;
						bh_q         <= dh_q;
						best_inter_q <= '0;
						best_union_q <= UNI_W'(1);
					end
				end
				ST_PICK: begin
					first_q <= 1'b0;
					// Strictly better only, so the earliest of equal scores stays.
					if (acc_gt) begin
						bx_q         <= dx_q;
						by_q         <= dy_q;
						bw_q         <= dw_q;
						bh_q         <= dh_q;
						best_inter_q <= cand_inter_q;
						best_union_q <= cand_union_q;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						tx_q         <= nx;
						ty_q         <= ny;
						tw_q         <= nw;
						th_q         <= nh;
						changed_q    <= !adopt &&
						                (nx != tx_q || ny != ty_q || nw != tw_q || nh != th_q);
						best_inter_q <= '0;
						best_union_q <= UNI_W'(1);
						first_q      <= 1'b1;
						out_valid_q  <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// The track registers double as the result word: they change only when a new
	// word is loaded, which waits until the previous one has been taken.
	assign trk.valid       = out_valid_q;
	assign trk.track_x     = tx_q;
	assign trk.track_y     = ty_q;
	assign trk.track_w     = tw_q;
	assign trk.track_h     = th_q;
	assign trk.track_valid = !adopt;
	assign trk.box_changed = changed_q;

endmodule

// File: rtl/ioubt_checker.sv
module ioubt_checker #(
	parameter int unsigned COORD_WIDTH = ioubt_pkg::COORD_WIDTH_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          det_valid,
	input logic                          det_ready,
	input logic                          trk_valid,
	input logic                          trk_ready,
	input logic signed [COORD_WIDTH-1:0] track_x,
	input logic signed [COORD_WIDTH-1:0] track_y,
	input logic        [COORD_WIDTH-2:0] track_w,
	input logic        [COORD_WIDTH-2:0] track_h,
	input logic                          track_valid,
	input logic                          box_changed
);

	// A stalled result word stays and keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		trk_valid && !trk_ready |=> trk_valid && $stable(track_x) && $stable(track_y)
			&& $stable(track_w) && $stable(track_h) && $stable(box_changed))
		else $error("result word changed while stalled");

	// Every detection occupies the shared unit, so no two are accepted back to back.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		det_valid && det_ready |=> !det_ready)
		else $error("detection accepted in consecutive cycles");

	// The valid flag of the track agrees with its size.
	a_track_valid: assert property (@(posedge clk) disable iff (!arst_n)
		trk_valid |-> track_valid == (track_w != '0 && track_h != '0))
		else $error("track_valid disagrees with track size");

endmodule

bind iou_box_tracker ioubt_checker #(
	.COORD_WIDTH (COORD_WIDTH)
) u_ioubt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.det_valid   (det.valid),
	.det_ready   (det.ready),
	.trk_valid   (trk.valid),
	.trk_ready   (trk.ready),
	.track_x     (trk.track_x),
	.track_y     (trk.track_y),
	.track_w     (trk.track_w),
	.track_h     (trk.track_h),
	.track_valid (trk.track_valid),
	.box_changed (trk.box_changed)
);

// File: tb/tb_iou_box_tracker.sv
module tb_iou_box_tracker;
	timeunit 1ns;
	timeprecision 1ps;

	import ioubt_pkg::*;

	localparam int CW = COORD_WIDTH_DEF;

	// Threshold register address: word index times four.
	localparam logic [PADDR_W-1:0] THR_ADDR = {REG_KEEP_THR, 2'b00};

	// This many cycles after the last result the block is certainly back at
	// rest.
	localparam int SETTLE_CYCLES = 40;
	// Cycles without any accepted word before the run is abandoned. The long
	// receiver hold-off below is the longest legitimate stall by far.
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	// Six random phases of this many detections come to about 1550 words
	// together with the directed part.
	localparam int PHASE_WORDS = 256;
	localparam int NUM_PHASES = 6;

	// One detection word as it goes into the block.
	typedef struct {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [CW-2:0] w;
		logic [CW-2:0] h;
		logic last;
	} det_word_t;

	// One track word as it comes out of the block.
	typedef struct {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [CW-2:0] w;
		logic [CW-2:0] h;
		logic valid;
		logic changed;
	} track_word_t;

	// A box held at full precision inside the predictor.
	typedef struct {
		longint x;
		longint y;
		longint w;
		longint h;
	} box_t;

	typedef enum {ROW_DET, ROW_CFG} row_kind_t;

	// One row of the directed stimulus: either a detection word, with the
	// expected track typed in where it is obvious, or a threshold write.
	typedef struct {
		row_kind_t kind;
		det_word_t d;
		bit typed;
		track_word_t want;
		logic [THR_W-1:0] thr;
	} row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	ioubt_det_if #(.COORD_WIDTH(CW)) det_bus ();
	ioubt_trk_if #(.COORD_WIDTH(CW)) trk_bus ();

	iou_box_tracker #(
		.COORD_WIDTH(CW)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.det     (det_bus.sink),
		.trk     (trk_bus.source)
	);

	// Predictor state: the track, the best candidate of the open frame with
	// its score held as an intersection/union pair, and the threshold.
	box_t trk_box;
	box_t cand_box;
	longint cand_inter;
	longint cand_union;
	bit frame_start;
	logic [THR_W-1:0] thr_reg;

	// Track words that the block still owes, oldest first.
	track_word_t pending_tracks[$];

	int mismatch_count;
	int send_idle_pct;
	int recv_idle_pct;
	// The stimulus bumps hold_req to ask the receiver for one long hold-off.
	int hold_req;
	int hold_seen;
	int hold_left;
	int stall_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic note_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Length of the overlap of two intervals, zero when they are apart.
	function automatic longint span_overlap(longint a0, longint alen, longint b0,
			longint blen);
		longint lo;
		longint hi;
		lo = (a0 > b0) ? a0 : b0;
		hi = (a0 + alen < b0 + blen) ? a0 + alen : b0 + blen;
		return (hi > lo) ? hi - lo : 0;
	endfunction

	// Advances the predictor by one accepted detection. Returns 1 when the
	// word closes its frame, and then r holds the expected track word.
	function automatic bit track_step(input det_word_t d, output track_word_t r);
		box_t db;
		box_t nb;
		longint inter;
		longint uni;
		bit adopt;
		bit changed;
		db.x = longint'(d.x);
		db.y = longint'(d.y);
		db.w = longint'(d.w);
		db.h = longint'(d.h);
		adopt = (trk_box.w == 0 || trk_box.h == 0);
		changed = 1'b0;
		// With no track the score is the plain area over a union of one, so
		// the same strict comparison picks the first box of largest area.
		if (adopt) begin
			inter = db.w * db.h;
			uni = 1;
		end else begin
			inter = span_overlap(db.x, db.w, trk_box.x, trk_box.w) *
				span_overlap(db.y, db.h, trk_box.y, trk_box.h);
			uni = db.w * db.h + trk_box.w * trk_box.h - inter;
		end
		// The first detection of a frame is always the starting candidate,
		// which is what keeps it when nothing in the frame scores above zero.
		if (frame_start) begin
			cand_box = db;
			cand_inter = 0;
			cand_union = 1;
		end
		if (inter * cand_union > cand_inter * uni) begin
			cand_box = db;
			cand_inter = inter;
			cand_union = uni;
		end
		frame_start = 1'b0;
		if (!d.last) begin
			return 1'b0;
		end
		frame_start = 1'b1;
		if (adopt) begin
			trk_box = cand_box;
		end else begin
			// Below threshold the track is dropped to an all-zero box.
			if (longint'(thr_reg) * cand_union > cand_inter * longint'(THR_ONE)) begin
				nb = '{0, 0, 0, 0};
			end else begin
				nb = cand_box;
			end
			changed = (nb.x != trk_box.x) || (nb.y != trk_box.y) ||
				(nb.w != trk_box.w) || (nb.h != trk_box.h);
			trk_box = nb;
		end
		cand_inter = 0;
		cand_union = 1;
		r.x = trk_box.x[CW-1:0];
		r.y = trk_box.y[CW-1:0];
		r.w = trk_box.w[CW-2:0];
		r.h = trk_box.h[CW-2:0];
		r.valid = (trk_box.w != 0) && (trk_box.h != 0);
		r.changed = changed;
		return 1'b1;
	endfunction

	function automatic logic signed [CW-1:0] sat_edge(longint v);
		longint lo;
		longint hi;
		lo = -(longint'(1) << (CW - 1));
		hi = (longint'(1) << (CW - 1)) - 1;
		v = (v < lo) ? lo : ((v > hi) ? hi : v);
		return v[CW-1:0];
	endfunction

	function automatic logic [CW-2:0] sat_size(longint v);
		longint hi;
		hi = (longint'(1) << (CW - 1)) - 1;
		v = (v < 0) ? 0 : ((v > hi) ? hi : v);
		return v[CW-2:0];
	endfunction

	// Draws one random detection. While a track is held, most detections are
	// jittered copies of it so that the IoU lands on both sides of the
	// threshold; the rest are anywhere in the coordinate range or small boxes
	// near the origin, some of them with zero width or height.
	function automatic det_word_t pick_detection(bit last);
		det_word_t d;
		logic [31:0] raw;
		int kind;
		int sw;
		int sh;
		kind = $urandom_range(99);
		if (trk_box.w != 0 && trk_box.h != 0 && kind < 75) begin
			if (kind < 6) begin
				d.x = trk_box.x[CW-1:0];
				d.y = trk_box.y[CW-1:0];
				d.w = trk_box.w[CW-2:0];
				d.h = trk_box.h[CW-2:0];
			end else begin
				sw = int'(trk_box.w) / 4 + 2;
				sh = int'(trk_box.h) / 4 + 2;
				d.x = sat_edge(trk_box.x + int'($urandom_range(2 * sw)) - sw);
				d.y = sat_edge(trk_box.y + int'($urandom_range(2 * sh)) - sh);
				d.w = sat_size(trk_box.w + int'($urandom_range(2 * sw)) - sw);
				d.h = sat_size(trk_box.h + int'($urandom_range(2 * sh)) - sh);
			end
		end else if (kind < 88) begin
			raw = $urandom;
			d.x = raw[CW-1:0];
			d.y = raw[31:32-CW];
			raw = $urandom;
			d.w = raw[CW-2:0];
			d.h = raw[31:33-CW];
		end else begin
			d.x = sat_edge(int'($urandom_range(4000)) - 2000);
			d.y = sat_edge(int'($urandom_range(4000)) - 2000);
			d.w = sat_size(int'($urandom_range(600)));
			d.h = sat_size(int'($urandom_range(600)));
		end
		d.last = last;
		return d;
	endfunction

	function automatic row_t det_row(int x, int y, int w, int h, bit last);
		row_t r;
		r.kind = ROW_DET;
		r.d.x = x[CW-1:0];
		r.d.y = y[CW-1:0];
		r.d.w = w[CW-2:0];
		r.d.h = h[CW-2:0];
		r.d.last = last;
		r.typed = 1'b0;
		r.want = '{default: '0};
		r.thr = '0;
		return r;
	endfunction

	// A closing detection whose resulting track word is written out by hand.
	function automatic row_t det_row_want(int x, int y, int w, int h, int tx, int ty,
			int tw, int th, bit tv, bit tc);
		row_t r;
		r = det_row(x, y, w, h, 1'b1);
		r.typed = 1'b1;
		r.want.x = tx[CW-1:0];
		r.want.y = ty[CW-1:0];
		r.want.w = tw[CW-2:0];
		r.want.h = th[CW-2:0];
		r.want.valid = tv;
		r.want.changed = tc;
		return r;
	endfunction

	function automatic row_t cfg_row(logic [THR_W-1:0] v);
		row_t r;
		r = det_row(0, 0, 0, 0, 1'b0);
		r.kind = ROW_CFG;
		r.thr = v;
		return r;
	endfunction

	// Offers one detection word, after a random gap, and holds it until the
	// block takes it. The predictor runs at the edge of acceptance.
	task automatic send_word(input det_word_t d, input bit typed, input track_word_t want);
		track_word_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			det_bus.valid <= 1'b0;
			@(posedge clk);
		end
		det_bus.valid <= 1'b1;
		det_bus.det_x <= d.x;
		det_bus.det_y <= d.y;
		det_bus.det_w <= d.w;
		det_bus.det_h <= d.h;
		det_bus.last_in_frame <= d.last;
		do @(posedge clk); while (!det_bus.ready);
		if (track_step(d, r)) begin
			pending_tracks.push_back(typed ? want : r);
		end
	endtask

	// Withdraws the input, waits for every owed track word and lets the
	// block settle, so that the threshold may be written safely.
	task automatic drain_and_settle();
		det_bus.valid <= 1'b0;
		while (pending_tracks.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [PDATA_W-1:0] wdata,
			output logic [PDATA_W-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= THR_ADDR;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Drains the block, writes the threshold, reads it back, and moves the predictor along.
	task automatic set_threshold(input logic [THR_W-1:0] v);
		logic [PDATA_W-1:0] rd;
		drain_and_settle();
		apb_access(1'b1, {{(PDATA_W - THR_W){1'b0}}, v}, rd);
		thr_reg = v;
		@(posedge clk);
		apb_access(1'b0, '0, rd);
		if (rd !== {{(PDATA_W - THR_W){1'b0}}, v}) begin
			note_mismatch($sformatf("keep threshold read back %0h, wrote %0h", rd, v));
		end
	endtask

	// Receiving side: checks each accepted track word against the oldest
	// expectation, then decides whether it is ready at the next edge. A hold
	// request from the stimulus keeps ready low for a long stretch, counted
	// here, while the sender keeps offering detections.
	always @(posedge clk) begin
		track_word_t want;
		if (arst_n && trk_bus.valid && trk_bus.ready) begin
			if (pending_tracks.size() == 0) begin
				note_mismatch("track word with no expectation waiting");
			end else begin
				want = pending_tracks.pop_front();
				if (trk_bus.track_x !== want.x)
					note_mismatch($sformatf("track_x %0d, want %0d", trk_bus.track_x,
						want.x));
				if (trk_bus.track_y !== want.y)
					note_mismatch($sformatf("track_y %0d, want %0d", trk_bus.track_y,
						want.y));
				if (trk_bus.track_w !== want.w)
					note_mismatch($sformatf("track_w %0d, want %0d", trk_bus.track_w,
						want.w));
				if (trk_bus.track_h !== want.h)
					note_mismatch($sformatf("track_h %0d, want %0d", trk_bus.track_h,
						want.h));
				if (trk_bus.track_valid !== want.valid)
					note_mismatch($sformatf("track_valid %b, want %b",
						trk_bus.track_valid, want.valid));
				if (trk_bus.box_changed !== want.changed)
					note_mismatch($sformatf("box_changed %b, want %b",
						trk_bus.box_changed, want.changed));
			end
		end
		if (hold_left > 0) begin
			trk_bus.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_req) begin
			trk_bus.ready <= 1'b0;
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
		end else begin
			trk_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: any accepted word on either side restarts the count.
	always @(posedge clk) begin
		if ((det_bus.valid && det_bus.ready) || (trk_bus.valid && trk_bus.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("Timeout: no word accepted for %0d cycles", WATCHDOG_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		row_t plan[$];
		det_word_t d;
		logic [THR_W-1:0] phase_thr[NUM_PHASES];
		int n;
		int len;

		// Every input is known from time zero, with reset held.
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		det_bus.valid = 1'b0;
		det_bus.det_x = '0;
		det_bus.det_y = '0;
		det_bus.det_w = '0;
		det_bus.det_h = '0;
		det_bus.last_in_frame = 1'b0;
		trk_bus.ready = 1'b0;
		mismatch_count = 0;
		hold_req = 0;
		hold_seen = 0;
		hold_left = 0;
		stall_cycles = 0;
		send_idle_pct = 14;
		recv_idle_pct = 71;

		// Predictor state after reset.
		trk_box = '{0, 0, 0, 0};
		cand_box = '{0, 0, 0, 0};
		cand_inter = 0;
		cand_union = 1;
		frame_start = 1'b1;
		thr_reg = THR_RESET;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. From reset the track is empty, so a lone detection
		// is adopted as it stands; the identical box is then kept unchanged,
		// and a box far away scores zero and clears the track.
		plan.push_back(det_row_want('h100, 'h200, 'h50, 'h60,
			'h100, 'h200, 'h50, 'h60, 1'b1, 1'b0));
		plan.push_back(det_row_want('h100, 'h200, 'h50, 'h60,
			'h100, 'h200, 'h50, 'h60, 1'b1, 1'b0));
		plan.push_back(det_row_want(-'h1000, -'h1000, 'h10, 'h10,
			0, 0, 0, 0, 1'b0, 1'b1));
		// Adoption where no detection has any area: the first one stays, and
		// since it is flat the track remains empty.
		plan.push_back(det_row(5, 6, 0, 7, 1'b0));
		plan.push_back(det_row_want(8, 9, 3, 0, 5, 6, 0, 7, 1'b0, 1'b0));
		// Adoption at the coordinate extremes: a tie on area goes to the
		// earlier box.
		plan.push_back(det_row(0, 0, 0, 0, 1'b0));
		plan.push_back(det_row(-32768, 32767, 32767, 1, 1'b0));
		plan.push_back(det_row_want(32767, -32768, 1, 32767,
			-32768, 32767, 32767, 1, 1'b1, 1'b0));
		// Tracking with two overlapping candidates of different IoU.
		plan.push_back(det_row(-32768, 32767, 16384, 1, 1'b0));
		plan.push_back(det_row(-16384, 32767, 32767, 1, 1'b1));
		// A zero threshold keeps even a disjoint box: the first detection of
		// the frame survives with an IoU of zero.
		plan.push_back(cfg_row('0));
		plan.push_back(det_row('h40, 'h40, 'h20, 'h20, 1'b1));
		// The largest threshold keeps the perfect match and drops the box shifted by one.
		plan.push_back(cfg_row('1));
		plan.push_back(det_row('h40, 'h40, 'h20, 'h20, 1'b1));
		plan.push_back(det_row('h41, 'h40, 'h20, 'h20, 1'b1));
		// Back to the reset threshold; adoption of the largest possible boxes.
		plan.push_back(cfg_row(THR_RESET));
		plan.push_back(det_row(32767, 32767, 32767, 32767, 1'b0));
		plan.push_back(det_row_want(-32768, -32768, 32767, 32767,
			32767, 32767, 32767, 32767, 1'b1, 1'b0));
		plan.push_back(det_row(32767, 32767, 32767, 32767, 1'b1));

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				set_threshold(plan[i].thr);
			end else begin
				send_word(plan[i].d, plan[i].typed, plan[i].want);
			end
		end

		// Random part, in phases of its own threshold. Frames hold one to
		// five detections. The first two phases have a slow receiver, the next
		// two a slow sender, the last two run flat out; the fifth phase opens with
		// the long hold-off on the result side.
		phase_thr[0] = THR_W'($urandom_range(2 ** THR_W - 1));
		phase_thr[1] = '0;
		phase_thr[2] = '1;
		phase_thr[3] = THR_W'($urandom_range(16384, 49152));
		phase_thr[4] = THR_RESET;
		phase_thr[5] = 16'h8000;
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			set_threshold(phase_thr[phase]);
			send_idle_pct = (phase < 2) ? 14 : ((phase < 4) ? 71 : 0);
			recv_idle_pct = (phase < 2) ? 71 : ((phase < 4) ? 14 : 0);
			if (phase == 4) begin
				hold_req++;
			end
			n = 0;
			while (n < PHASE_WORDS) begin
				len = $urandom_range(1, 5);
				for (int k = 0; k < len; k++) begin
					d = pick_detection(k == len - 1);
					send_word(d, 1'b0, '{default: '0});
					n++;
				end
			end
		end

		drain_and_settle();
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
